### hw/rtl/jsu_pkg.sv
// Shared types, constants and helpers of the JSON string unescaper.
package jsu_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int JOB_SLOTS   = 3;

   localparam logic [2:0] STATUS_BYTE     = 3'd0;
   localparam logic [2:0] STATUS_DONE     = 3'd1;
   localparam logic [2:0] STATUS_NO_OPEN  = 3'd2;
   localparam logic [2:0] STATUS_UNTERM   = 3'd3;
   localparam logic [2:0] STATUS_BAD_ESC  = 3'd4;
   localparam logic [2:0] STATUS_BAD_HEX  = 3'd5;

   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [5:0] UTF8_MASK  = 6'h3F;
   localparam logic [15:0] UTF8_3BYTE_MIN = 16'h0800;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       source_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [JOB_SLOTS-1:0][7:0] data;
      logic [1:0]                count;
      logic [2:0]                status;
   } job_type;

   typedef struct packed {
      logic       is_digit;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type h;
      h.is_digit = 1'b1;
      h.value    = 4'd0;
      if (c >= "0" && c <= "9") begin
         h.value = 4'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         h.value = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         h.value = 4'(c - "A" + 8'd10);
      end else begin
         h.is_digit = 1'b0;
      end
      return h;
   endfunction

endpackage

### hw/rtl/jsu_front.sv
// Front end: accepts text bytes, tracks string mode and builds result jobs.
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_payload,
   input  logic             queue_full,
   output logic             push,
   output jsu_pkg::job_type push_job
);

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_STR  = 4'b0010,
      MODE_ESC  = 4'b0100,
      MODE_HEX  = 4'b1000
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_value_ff, code_value_in;
   logic        hex_stopped_ff, hex_stopped_in;

   logic             accept;
   logic [7:0]       c;
   logic             src_end;
   jsu_pkg::hex_type hex;
   logic [15:0]      cp;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_payload.in_byte;
   assign src_end   = req_payload.source_end;
   assign hex       = jsu_pkg::hex_digit(c);

   always_comb begin
      mode_in        = mode_ff;
      hex_count_in   = hex_count_ff;
      code_value_in  = code_value_ff;
      hex_stopped_in = hex_stopped_ff;
      push           = 1'b0;
      push_job       = '0;
      push_job.count = 2'd1;
      cp             = code_value_ff;
      if (accept) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (src_end) begin
                  push            = 1'b1;
                  push_job.status = jsu_pkg::STATUS_NO_OPEN;
               end else if (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
                  push = 1'b0;
               end else if (c == "\"") begin
                  mode_in = MODE_STR;
               end else begin
                  push            = 1'b1;
                  push_job.status = jsu_pkg::STATUS_NO_OPEN;
               end
            end
            MODE_STR: begin
               if (src_end) begin
                  push            = 1'b1;
                  push_job.status = jsu_pkg::STATUS_UNTERM;
                  mode_in         = MODE_IDLE;
               end else if (c == "\"") begin
                  push            = 1'b1;
                  push_job.status = jsu_pkg::STATUS_DONE;
                  mode_in         = MODE_IDLE;
               end else if (c == "\\") begin
                  mode_in = MODE_ESC;
               end else begin
                  push             = 1'b1;
                  push_job.data[0] = c;
               end
            end
            MODE_ESC: begin
               if (src_end) begin
                  push            = 1'b1;
                  push_job.status = jsu_pkg::STATUS_BAD_ESC;
                  mode_in         = MODE_IDLE;
               end else if (c == "u") begin
                  mode_in        = MODE_HEX;
                  hex_count_in   = 2'd0;
                  code_value_in  = '0;
                  hex_stopped_in = 1'b0;
               end else begin
                  push    = 1'b1;
                  mode_in = MODE_STR;
                  unique case (c)
                     "n":     push_job.data[0] = 8'h0A;
                     "r":     push_job.data[0] = 8'h0D;
                     "t":     push_job.data[0] = 8'h09;
                     "b":     push_job.data[0] = 8'h08;
                     "f":     push_job.data[0] = 8'h0C;
                     default: push_job.data[0] = c;
                  endcase
               end
            end
            MODE_HEX: begin
               if (src_end) begin
                  push            = 1'b1;
                  push_job.status = jsu_pkg::STATUS_BAD_HEX;
                  mode_in         = MODE_IDLE;
                  hex_count_in    = 2'd0;
                  code_value_in   = '0;
                  hex_stopped_in  = 1'b0;
               end else begin
                  if (!hex_stopped_ff) begin
                     if (hex.is_digit) begin
                        cp = {code_value_ff[11:0], hex.value};
                     end else begin
                        hex_stopped_in = 1'b1;
                     end
                  end
                  code_value_in = cp;
                  hex_count_in  = hex_count_ff + 2'd1;
                  if (hex_count_ff == 2'd3) begin
                     push           = 1'b1;
                     mode_in        = MODE_STR;
                     hex_count_in   = 2'd0;
                     code_value_in  = '0;
                     hex_stopped_in = 1'b0;
                     if (cp[15:7] == '0) begin
                        push_job.data[0] = cp[7:0];
                     end else if (cp < jsu_pkg::UTF8_3BYTE_MIN) begin
                        push_job.count   = 2'd2;
                        push_job.data[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
                        push_job.data[1] = jsu_pkg::UTF8_CONT
                                           | {2'b00, cp[5:0] & jsu_pkg::UTF8_MASK};
                     end else begin
                        push_job.count   = 2'd3;
                        push_job.data[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
                        push_job.data[1] = jsu_pkg::UTF8_CONT
                                           | {2'b00, cp[11:6] & jsu_pkg::UTF8_MASK};
                        push_job.data[2] = jsu_pkg::UTF8_CONT
                                           | {2'b00, cp[5:0] & jsu_pkg::UTF8_MASK};
                     end
                  end
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         hex_count_ff   <= '0;
         code_value_ff  <= '0;
         hex_stopped_ff <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         hex_count_ff   <= hex_count_in;
         code_value_ff  <= code_value_in;
         hex_stopped_ff <= hex_stopped_in;
      end
   end

endmodule

### hw/rtl/jsu_queue.sv
// Job queue between the front end and the result serialiser.
module jsu_queue #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output jsu_pkg::job_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   jsu_pkg::job_type store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign head    = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/jsu_back.sv
// Back end: splits queued jobs into result bytes behind an output register.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  jsu_pkg::job_type head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_payload
);

   logic             rsp_valid_ff, rsp_valid_in;
   jsu_pkg::rsp_type rsp_payload_ff, rsp_payload_in;
   logic [1:0]       idx_ff, idx_in;
   logic             load, is_last;

   assign load    = (!rsp_valid_ff || rsp_ready) && !empty;
   assign is_last = (idx_ff == head.count - 2'd1);
   assign pop     = load && is_last;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      idx_in         = idx_ff;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.out_byte = head.data[idx_ff];
         rsp_payload_in.status   = head.status;
         rsp_payload_in.last     = is_last;
         idx_in                  = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### hw/rtl/json_string_unescaper_utf8_core.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   req     | in        | req_valid / req_ready  | req_payload (in_byte, source_end)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_payload (out_byte, status, last)
//
// One request is taken per cycle while the job queue has room (QUEUE_DEPTH jobs).
// The back end sends one result per cycle unless rsp_ready stalls it; a \u escape
// giving 2 or 3 UTF-8 bytes occupies it for one result per byte. A result passes
// the job queue and the output register. Reset clears the string mode, the queue
// and rsp_valid. A stalled rsp side fills the queue, after which req_ready drops.
module json_string_unescaper_utf8_core #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_payload
);

   logic             queue_full, queue_empty, push, pop;
   jsu_pkg::job_type push_job, head;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   jsu_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head     (head)
   );

   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### verif/json_string_unescaper_utf8_core_tb.sv
// Self-checking testbench of the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

class unescape_scoreboard;
   typedef enum logic [1:0] {SCAN_IDLE, SCAN_STRING, SCAN_ESCAPE, SCAN_HEX} scan_mode_type;

   scan_mode_type mode;
   logic [2:0] hex_count;
   logic [15:0] code_value;
   bit hex_stopped;

   jsu_pkg::rsp_type due_results[$];
   int errors;
   int requests;
   int results;
   int status_seen[8];

   function new();
      go_idle();
      errors = 0;
      requests = 0;
      results = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
   endfunction

   function void go_idle();
      mode = SCAN_IDLE;
      hex_count = '0;
      code_value = '0;
      hex_stopped = 1'b0;
   endfunction

   function jsu_pkg::rsp_type result_of(logic [7:0] b, logic [2:0] s);
      jsu_pkg::rsp_type r;
      r.out_byte = b;
      r.status = s;
      r.last = 1'b0;
      return r;
   endfunction

   function void note_request(jsu_pkg::req_type r);
      jsu_pkg::rsp_type batch[$];
      logic [7:0] c;
      logic [15:0] cp;
      int d;
      c = r.in_byte;
      requests++;
      case (mode)
         SCAN_IDLE: begin
            if (r.source_end) begin
               batch = {batch, result_of(8'h00, jsu_pkg::STATUS_NO_OPEN)};
               go_idle();
            end else if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
            end else if (c == "\"") begin
               mode = SCAN_STRING;
            end else begin
               batch = {batch, result_of(8'h00, jsu_pkg::STATUS_NO_OPEN)};
               go_idle();
            end
         end
         SCAN_STRING: begin
            if (r.source_end) begin
               batch = {batch, result_of(8'h00, jsu_pkg::STATUS_UNTERM)};
               go_idle();
            end else if (c == "\"") begin
               batch = {batch, result_of(8'h00, jsu_pkg::STATUS_DONE)};
               go_idle();
            end else if (c == "\\") begin
               mode = SCAN_ESCAPE;
            end else begin
               batch = {batch, result_of(c, jsu_pkg::STATUS_BYTE)};
            end
         end
         SCAN_ESCAPE: begin
            if (r.source_end) begin
               batch = {batch, result_of(8'h00, jsu_pkg::STATUS_BAD_ESC)};
               go_idle();
            end else if (c == "u") begin
               mode = SCAN_HEX;
               hex_count = '0;
               code_value = '0;
               hex_stopped = 1'b0;
            end else begin
               case (c)
                  "n": c = 8'h0A;
                  "r": c = 8'h0D;
                  "t": c = 8'h09;
                  "b": c = 8'h08;
                  "f": c = 8'h0C;
                  default: ;
               endcase
               batch = {batch, result_of(c, jsu_pkg::STATUS_BYTE)};
               mode = SCAN_STRING;
            end
         end
         default: begin
            if (r.source_end) begin
               batch = {batch, result_of(8'h00, jsu_pkg::STATUS_BAD_HEX)};
               go_idle();
            end else begin
               if (!hex_stopped) begin
                  d = -1;
                  if (c >= "0" && c <= "9") d = c - "0";
                  else if (c >= "a" && c <= "f") d = c - "a" + 10;
                  else if (c >= "A" && c <= "F") d = c - "A" + 10;
                  if (d < 0) hex_stopped = 1'b1;
                  else code_value = {code_value[11:0], 4'(d)};
               end
               hex_count = hex_count + 3'd1;
               if (hex_count >= 3'd4) begin
                  cp = code_value;
                  if (cp < 16'h0080) begin
                     batch = {batch, result_of(cp[7:0], jsu_pkg::STATUS_BYTE)};
                  end else if (cp < jsu_pkg::UTF8_3BYTE_MIN) begin
                     batch = {batch, result_of(jsu_pkg::UTF8_LEAD2 | {3'b0, cp[10:6]},
                                               jsu_pkg::STATUS_BYTE)};
                     batch = {batch, result_of(jsu_pkg::UTF8_CONT | {2'b0, cp[5:0]},
                                               jsu_pkg::STATUS_BYTE)};
                  end else begin
                     batch = {batch, result_of(jsu_pkg::UTF8_LEAD3 | {4'b0, cp[15:12]},
                                               jsu_pkg::STATUS_BYTE)};
                     batch = {batch, result_of(jsu_pkg::UTF8_CONT | {2'b0, cp[11:6]},
                                               jsu_pkg::STATUS_BYTE)};
                     batch = {batch, result_of(jsu_pkg::UTF8_CONT | {2'b0, cp[5:0]},
                                               jsu_pkg::STATUS_BYTE)};
                  end
                  mode = SCAN_STRING;
                  hex_count = '0;
                  code_value = '0;
                  hex_stopped = 1'b0;
               end
            end
         end
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) due_results = {due_results, batch[i]};
   endfunction

   function void check_field(string name, int expected, int actual);
      if (expected != actual) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      end
   endfunction

   function void check_response(jsu_pkg::rsp_type got);
      jsu_pkg::rsp_type want;
      results++;
      status_seen[got.status]++;
      if (due_results.size() == 0) begin
         errors++;
         $display("%0t: unexpected result, expected none, actual byte %h status %0d last %b",
                  $time, got.out_byte, got.status, got.last);
         return;
      end
      want = due_results.pop_front();
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("status", want.status, got.status);
      check_field("last", want.last, got.last);
   endfunction
endclass

module json_string_unescaper_utf8_core_tb;

   localparam int CLOCK_HALF = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 410;
   localparam int HOLD_OFF_CYCLES = 90;
   localparam int DRAIN_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   jsu_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   jsu_pkg::rsp_type rsp_payload;

   unescape_scoreboard board = new();

   int cycles = 0;
   int items_sent = 0;
   int tx_idle_pct = 30;
   int rx_idle_pct = 30;
   int hold_off_requests = 0;
   int hold_off_taken = 0;
   int hold_left = 0;

   json_string_unescaper_utf8_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_payload);
         if (rsp_valid && rsp_ready) board.check_response(rsp_payload);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("json_string_unescaper_utf8_core_tb: errors");
         $finish;
      end
   end

   // hold off the result side when asked, otherwise stall at random
   always @(posedge clock) begin
      if (hold_off_requests != hold_off_taken) begin
         hold_off_taken = hold_off_requests;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic offer(input logic [7:0] b, input logic e);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_payload <= '{in_byte: b, source_end: e};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic offer_text(input string s);
      for (int i = 0; i < s.len(); i++) offer(s[i], 1'b0);
   endtask

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(3))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0A;
         default: return 8'h0D;
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + 8'(n);
      if ($urandom_range(1) == 0) return "a" + 8'(n) - 8'd10;
      return "A" + 8'(n) - 8'd10;
   endfunction

   task automatic send_unicode(input int digits);
      logic [15:0] cp;
      logic [7:0] chars[4];
      int spoil;
      case ($urandom_range(2))
         0: cp = 16'($urandom_range(16'h007F));
         1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
         default: cp = 16'($urandom_range(16'hFFFF));
      endcase
      for (int i = 0; i < 4; i++) chars[i] = hex_char(cp[15 - 4*i -: 4]);
      if ($urandom_range(99) < 25) begin
         spoil = $urandom_range(3);
         chars[spoil] = (($urandom_range(3) == 0) ? 8'(8'h22) : 8'($urandom_range(255)));
      end
      offer_text("\\u");
      for (int i = 0; i < digits; i++) offer(chars[i], 1'b0);
   endtask

   task automatic send_random_string();
      string escapes;
      logic [7:0] b;
      int parts;
      int kind;
      escapes = "nrtbf\"\\/";
      repeat ($urandom_range(2)) offer(blank_byte(), 1'b0);
      offer("\"", 1'b0);
      parts = $urandom_range(6);
      for (int i = 0; i < parts; i++) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            b = 8'($urandom_range(255));
            if (b == "\"" || b == "\\") b = b ^ 8'h01;
            offer(b, 1'b0);
         end else if (kind < 70) begin
            offer("\\", 1'b0);
            if ($urandom_range(4) == 0) offer(8'($urandom_range(255)), 1'b0);
            else offer(escapes[$urandom_range(escapes.len() - 1)], 1'b0);
         end else begin
            send_unicode(4);
         end
      end
      kind = $urandom_range(99);
      if (kind < 80) begin
         offer("\"", 1'b0);
      end else if (kind < 86) begin
         offer(8'($urandom_range(255)), 1'b1);
      end else if (kind < 92) begin
         offer("\\", 1'b0);
         offer(8'($urandom_range(255)), 1'b1);
      end else begin
         send_unicode($urandom_range(3));
         offer(8'($urandom_range(255)), 1'b1);
      end
      // drop some noise between strings
      if ($urandom_range(99) < 15) begin
         if ($urandom_range(1) == 0) begin
            b = 8'($urandom_range(255));
            if (b == "\"") b = "#";
            offer(b, 1'b0);
         end else begin
            offer(8'($urandom_range(255)), 1'b1);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      offer(8'h20, 1'b0);
      offer(8'h09, 1'b0);
      offer(8'h0A, 1'b0);
      offer(8'h0D, 1'b0);
      offer("x", 1'b0);
      offer(8'hA5, 1'b1);
      offer("\"", 1'b0);
      offer(8'hFF, 1'b0);
      offer_text("\\n");
      offer_text("\\uFfFf");
      offer(8'h00, 1'b1);
      offer_text("\"\\");
      offer(8'hFF, 1'b1);
      offer_text("\"\\u7");
      offer(8'h5A, 1'b1);

      while (items_sent < 180) send_random_string();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (items_sent < 270) send_random_string();

      // hold the result side while requests keep coming
      hold_off_requests++;
      while (items_sent < 330) send_random_string();

      tx_idle_pct = 30;
      rx_idle_pct = 30;
      while (items_sent < RANDOM_ITEMS) send_random_string();
      req_valid <= 1'b0;

      while (board.due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d results: %0d bytes, %0d strings closed",
               board.requests, board.results, board.status_seen[jsu_pkg::STATUS_BYTE],
               board.status_seen[jsu_pkg::STATUS_DONE]);
      $display("error reports: %0d no quote, %0d unterminated, %0d bad escape, %0d bad hex",
               board.status_seen[jsu_pkg::STATUS_NO_OPEN],
               board.status_seen[jsu_pkg::STATUS_UNTERM],
               board.status_seen[jsu_pkg::STATUS_BAD_ESC],
               board.status_seen[jsu_pkg::STATUS_BAD_HEX]);
      if (board.errors == 0 && board.due_results.size() == 0) begin
         $display("json_string_unescaper_utf8_core_tb: clean");
      end else begin
         $display("json_string_unescaper_utf8_core_tb: errors");
      end
      $finish;
   end
endmodule

### files.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescaper_utf8_core.sv
verif/json_string_unescaper_utf8_core_tb.sv
